[hw/rtl/vip_pkg.sv]
// ----------------------------------------------------------------------------
// vip_pkg: shared types and constants of the intensity projection unit
// Sizes of the accumulator store, register widths, mode codes and the
// structures passed between the submodules.
// ----------------------------------------------------------------------------
package vip_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_DEPTH  = 256;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int SLICE_W   = $clog2(MAX_DEPTH);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int ACC_DEPTH = 1 << ADDR_W;

  localparam int VOX_W      = 16;
  localparam int ACC_W      = 24;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 10;
  localparam int DEPTH_W    = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_CNT_W  = $clog2(ACC_W);

  typedef enum logic [1:0] {
    MODE_MIP   = 2'd0,
    MODE_AIP   = 2'd1,
    MODE_MINIP = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_DEPTH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    mode_t                mode;
    logic [WIDTH_W-1:0]   width;
    logic [HEIGHT_W-1:0]  height;
    logic [DEPTH_W-1:0]   depth;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0]   dividend;
    logic [DEPTH_W-1:0] divisor;
    logic               avg;
    logic               last;
  } req_t;

endpackage

[hw/rtl/vip_cfg.sv]
// ----------------------------------------------------------------------------
// vip_cfg: configuration registers
// Holds mode and the volume dimensions. Dimensions are stored already
// clamped to their legal ranges; a write of the unused mode code is dropped.
// ----------------------------------------------------------------------------
module vip_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vip_pkg::CFG_DATA_W-1:0] cfg_data,
  output vip_pkg::cfg_t                  cfg
);

  vip_pkg::cfg_t cfg_r;
  vip_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  function automatic logic [vip_pkg::WIDTH_W-1:0] clamp_width(
    input logic [vip_pkg::WIDTH_W-1:0] v
  );
    logic [vip_pkg::WIDTH_W-1:0] r;
    if (v == '0) begin
      r = vip_pkg::WIDTH_W'(1);
    end else if (v > vip_pkg::WIDTH_W'(vip_pkg::MAX_WIDTH)) begin
      r = vip_pkg::WIDTH_W'(vip_pkg::MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [vip_pkg::HEIGHT_W-1:0] clamp_height(
    input logic [vip_pkg::HEIGHT_W-1:0] v
  );
    logic [vip_pkg::HEIGHT_W-1:0] r;
    if (v == '0) begin
      r = vip_pkg::HEIGHT_W'(1);
    end else if (v > vip_pkg::HEIGHT_W'(vip_pkg::MAX_HEIGHT)) begin
      r = vip_pkg::HEIGHT_W'(vip_pkg::MAX_HEIGHT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [vip_pkg::DEPTH_W-1:0] clamp_depth(
    input logic [vip_pkg::DEPTH_W-1:0] v
  );
    logic [vip_pkg::DEPTH_W-1:0] r;
    if (v == '0) begin
      r = vip_pkg::DEPTH_W'(1);
    end else if (v > vip_pkg::DEPTH_W'(vip_pkg::MAX_DEPTH)) begin
      r = vip_pkg::DEPTH_W'(vip_pkg::MAX_DEPTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (vip_pkg::cfg_idx_t'(cfg_index))
        vip_pkg::CFG_MODE: begin
          if (cfg_data[1:0] <= 2'(vip_pkg::MODE_MINIP)) begin
            cfg_nxt.mode = vip_pkg::mode_t'(cfg_data[1:0]);
          end
        end
        vip_pkg::CFG_WIDTH:  cfg_nxt.width  = clamp_width(cfg_data[vip_pkg::WIDTH_W-1:0]);
        vip_pkg::CFG_HEIGHT: cfg_nxt.height = clamp_height(cfg_data[vip_pkg::HEIGHT_W-1:0]);
        vip_pkg::CFG_DEPTH:  cfg_nxt.depth  = clamp_depth(cfg_data[vip_pkg::DEPTH_W-1:0]);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= vip_pkg::MODE_MIP;
      cfg_r.width  <= vip_pkg::WIDTH_W'(256);
      cfg_r.height <= vip_pkg::HEIGHT_W'(256);
      cfg_r.depth  <= vip_pkg::DEPTH_W'(128);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/vip_accum.sv]
// ----------------------------------------------------------------------------
// vip_accum: voxel position counters and accumulator read-modify-write
// A voxel request reads its pixel accumulator at acceptance; the combined
// value is written back from stage s1 and, on the last slice, handed on.
// ----------------------------------------------------------------------------
module vip_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vip_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [vip_pkg::VOX_W-1:0] in_voxel,
  output logic                      req_valid,
  input  logic                      req_ready,
  output vip_pkg::req_t             req
);

  logic [vip_pkg::ACC_W-1:0]   acc_mem_r [vip_pkg::ACC_DEPTH];
  logic [vip_pkg::ACC_W-1:0]   rdata_r;

  logic [vip_pkg::COL_W-1:0]   col_r,   col_nxt;
  logic [vip_pkg::ROW_W-1:0]   row_r,   row_nxt;
  logic [vip_pkg::SLICE_W-1:0] slice_r, slice_nxt;

  logic                        s1_valid_r;
  logic [vip_pkg::VOX_W-1:0]   s1_voxel_r;
  logic [vip_pkg::ADDR_W-1:0]  s1_addr_r;
  logic                        s1_first_r;
  logic                        s1_emit_r;
  logic                        s1_last_r;

  logic                        fwd_hit_r;
  logic [vip_pkg::ACC_W-1:0]   fwd_data_r;

  logic                        accept;
  logic                        s1_done;
  logic [vip_pkg::ADDR_W-1:0]  rd_addr;
  logic                        end_col, end_row, last_slice;
  logic [vip_pkg::ACC_W-1:0]   acc_old, acc_new, vox_ext;

  assign rd_addr    = {row_r, col_r};
  assign end_col    = (vip_pkg::WIDTH_W'(col_r) + 1'b1) >= cfg.width;
  assign end_row    = (vip_pkg::HEIGHT_W'(row_r) + 1'b1) >= cfg.height;
  assign last_slice = (vip_pkg::DEPTH_W'(slice_r) + 1'b1) >= cfg.depth;

  assign s1_done  = s1_valid_r && (!s1_emit_r || req_ready);
  assign in_ready = !s1_valid_r || s1_done;
  assign accept   = in_valid && in_ready;

  // A write-back at the same edge as the read of the same entry is not yet
  // visible in the array, so the written value is forwarded instead.
  assign acc_old = fwd_hit_r ? fwd_data_r : rdata_r;
  assign vox_ext = vip_pkg::ACC_W'(s1_voxel_r);

  always_comb begin
    if (s1_first_r) begin
      acc_new = vox_ext;
    end else begin
      case (cfg.mode)
        vip_pkg::MODE_AIP:   acc_new = acc_old + vox_ext;
        vip_pkg::MODE_MINIP: acc_new = (vox_ext < acc_old) ? vox_ext : acc_old;
        default:             acc_new = (vox_ext > acc_old) ? vox_ext : acc_old;
      endcase
    end
  end

  assign req_valid    = s1_valid_r && s1_emit_r;
  assign req.dividend = acc_new;
  assign req.divisor  = cfg.depth;
  assign req.avg      = (cfg.mode == vip_pkg::MODE_AIP);
  assign req.last     = s1_last_r;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    slice_nxt = slice_r;
    if (end_col) begin
      col_nxt = '0;
      if (end_row) begin
        row_nxt   = '0;
        slice_nxt = last_slice ? '0 : slice_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= acc_mem_r[rd_addr];
    end
    if (s1_done) begin
      acc_mem_r[s1_addr_r] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      slice_r    <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        slice_r   <= slice_nxt;
        fwd_hit_r <= s1_done && (s1_addr_r == rd_addr);
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_voxel_r <= in_voxel;
      s1_addr_r  <= rd_addr;
      s1_first_r <= (slice_r == '0);
      s1_emit_r  <= last_slice;
      s1_last_r  <= end_col && end_row;
      fwd_data_r <= acc_new;
    end
  end

endmodule

[hw/rtl/vip_div.sv]
// ----------------------------------------------------------------------------
// vip_div: result stage with depth divider
// Maximum and minimum results pass straight to the output register. Sums are
// divided by the depth with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vip_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  vip_pkg::req_t             req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [vip_pkg::VOX_W-1:0] out_pixel,
  output logic                      out_last_pixel
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                         state_r;
  logic [vip_pkg::ACC_W-1:0]      quo_r;
  logic [vip_pkg::DEPTH_W-1:0]    rem_r;
  logic [vip_pkg::DEPTH_W-1:0]    den_r;
  logic [vip_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           last_r;

  logic                           take;
  logic [vip_pkg::DEPTH_W:0]      trial;
  logic                           q_bit;
  logic [vip_pkg::DEPTH_W:0]      diff;

  assign req_ready = (state_r == ST_IDLE) || ((state_r == ST_HOLD) && out_ready);
  assign take      = req_valid && req_ready;

  assign trial = {rem_r, quo_r[vip_pkg::ACC_W-1]};
  assign q_bit = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  assign out_valid      = (state_r == ST_HOLD);
  assign out_pixel      = quo_r[vip_pkg::VOX_W-1:0];
  assign out_last_pixel = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE, ST_HOLD: begin
          if (take) begin
            state_r <= req.avg ? ST_DIV : ST_HOLD;
            cnt_r   <= '0;
          end else if (state_r == ST_HOLD && out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == vip_pkg::DIV_CNT_W'(vip_pkg::ACC_W - 1)) begin
            state_r <= ST_HOLD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      quo_r  <= req.dividend;
      rem_r  <= '0;
      den_r  <= req.divisor;
      last_r <= req.last;
    end else if (state_r == ST_DIV) begin
      quo_r <= {quo_r[vip_pkg::ACC_W-2:0], q_bit};
      rem_r <= q_bit ? diff[vip_pkg::DEPTH_W-1:0] : trial[vip_pkg::DEPTH_W-1:0];
    end
  end

endmodule

[hw/rtl/volume_intensity_projection_unit.sv]
// Projects a volume streamed slice by slice, row by row (column fastest)
// onto one image by maximum, average or minimum along depth. The pixel
// accumulator is read from a single-port-read, single-port-write 24-bit
// memory at acceptance and written back from the s1 registers; voxels
// stream back to back unless the result stage stalls. Each voxel of the
// last slice yields a pixel through the s1 and output registers; in
// average mode it passes the depth divider, one quotient bit a cycle,
// which takes no new pixel while dividing. The accumulator memory needs no
// clearing after reset: slice 0 loads each entry and ignores what it reads.
// The user must write configuration only while the unit is idle (not enforced).
// ----------------------------------------------------------------------------
// volume_intensity_projection_unit: top level
// Connects the configuration registers, the accumulator stage and the
// result stage.
// ----------------------------------------------------------------------------
module volume_intensity_projection_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vip_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vip_pkg::VOX_W-1:0]      in_voxel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vip_pkg::VOX_W-1:0]      out_pixel,
  output logic                           out_last_pixel
);

  vip_pkg::cfg_t cfg;
  vip_pkg::req_t req;
  logic          req_valid;
  logic          req_ready;

  vip_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vip_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_voxel  (in_voxel),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  vip_div u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_last_pixel (out_last_pixel)
  );

`ifndef SYNTH
  // A stalled pixel request must hold its value until the result stage takes it.
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && !req_ready) |=> (req_valid && $stable(req.dividend)))
    else $error("pixel request changed while stalled");

  // Maximum and minimum pixels reach the output the cycle after handoff.
  a_direct_out: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready && !req.avg) |=> out_valid)
    else $error("direct pixel did not reach the output");

  // An average pixel is still in the divider the cycle after handoff.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready && req.avg) |=> (!out_valid && !req_ready))
    else $error("divider skipped its iterations");
`endif

endmodule

[tb/sv/tb_volume_intensity_projection_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_intensity_projection_unit: self-checking testbench
// Streams small volumes through the projection unit in all three modes and
// predicts every projected pixel from its own copy of the accumulators,
// counters and registers. Covers zero and oversized register values, the
// deepest stack, register changes mid-slice, random bubbles on both
// sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_volume_intensity_projection_unit;

  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned LONG_HOLD     = 240;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam logic [1:0]  INVALID_MODE  = 2'd3;

  typedef struct packed {
    logic [vip_pkg::VOX_W-1:0] pixel;
    logic                      last_pixel;
  } pixel_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [vip_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vip_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [vip_pkg::VOX_W-1:0]      in_voxel;
  logic                           out_valid;
  logic                           out_ready;
  logic [vip_pkg::VOX_W-1:0]      out_pixel;
  logic                           out_last_pixel;

  // Projection state kept by the testbench.
  bit [vip_pkg::ACC_W-1:0]      acc_store [vip_pkg::ACC_DEPTH];
  int unsigned                  col_cnt;
  int unsigned                  row_cnt;
  int unsigned                  slice_cnt;
  vip_pkg::mode_t               proj_mode;
  logic [vip_pkg::WIDTH_W-1:0]  img_width;
  logic [vip_pkg::HEIGHT_W-1:0] img_height;
  logic [vip_pkg::DEPTH_W-1:0]  stack_depth;

  pixel_t      expected_pixels[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned pixels_checked;
  int unsigned volumes_done;
  bit          bubbles_on = 1'b1;
  bit          stream_dirty;
  int unsigned hold_req;

  volume_intensity_projection_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_voxel       (in_voxel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_register(input vip_pkg::cfg_idx_t idx,
                                         input logic [vip_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      vip_pkg::CFG_MODE: begin
        // An unknown mode code leaves the previous mode in place.
        if (d[1:0] <= vip_pkg::MODE_MINIP) proj_mode = vip_pkg::mode_t'(d[1:0]);
      end
      vip_pkg::CFG_WIDTH:  img_width   = d[vip_pkg::WIDTH_W-1:0];
      vip_pkg::CFG_HEIGHT: img_height  = d[vip_pkg::HEIGHT_W-1:0];
      vip_pkg::CFG_DEPTH:  stack_depth = d[vip_pkg::DEPTH_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void project_voxel(input logic [vip_pkg::VOX_W-1:0] v);
    int unsigned                ew, eh, ed, col, row;
    logic [vip_pkg::ACC_W-1:0]  acc;
    logic [vip_pkg::ADDR_W-1:0] addr;
    bit                         end_col, end_row, last_slice;
    pixel_t                     p;
    ew = clamp_dim(img_width, vip_pkg::MAX_WIDTH);
    eh = clamp_dim(img_height, vip_pkg::MAX_HEIGHT);
    ed = clamp_dim(stack_depth, vip_pkg::MAX_DEPTH);
    col = (col_cnt < vip_pkg::MAX_WIDTH) ? col_cnt : vip_pkg::MAX_WIDTH - 1;
    row = (row_cnt < vip_pkg::MAX_HEIGHT) ? row_cnt : vip_pkg::MAX_HEIGHT - 1;
    addr = vip_pkg::ADDR_W'(row * vip_pkg::MAX_WIDTH + col);
    end_col = (col_cnt + 1 >= ew);
    end_row = (row_cnt + 1 >= eh);
    last_slice = (slice_cnt + 1 >= ed);
    if (slice_cnt == 0) begin
      acc = vip_pkg::ACC_W'(v);
    end else begin
      acc = acc_store[addr];
      case (proj_mode)
        vip_pkg::MODE_AIP:   acc = acc + vip_pkg::ACC_W'(v);
        vip_pkg::MODE_MINIP: if (vip_pkg::ACC_W'(v) < acc) acc = vip_pkg::ACC_W'(v);
        default:             if (vip_pkg::ACC_W'(v) > acc) acc = vip_pkg::ACC_W'(v);
      endcase
    end
    acc_store[addr] = acc;
    if (last_slice) begin
      if (proj_mode == vip_pkg::MODE_AIP) p.pixel = vip_pkg::VOX_W'(acc / ed);
      else p.pixel = acc[vip_pkg::VOX_W-1:0];
      p.last_pixel = end_col && end_row;
      expected_pixels.insert(expected_pixels.size(), p);
    end
    if (end_col) begin
      col_cnt = 0;
      if (end_row) begin
        row_cnt = 0;
        slice_cnt = last_slice ? 0 : slice_cnt + 1;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic logic [vip_pkg::VOX_W-1:0] pick_voxel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return vip_pkg::VOX_W'($urandom_range(0, 15));
      default: return vip_pkg::VOX_W'($urandom);
    endcase
  endfunction

  // Result side: random stalls, plus a long hold when a test asks for one.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (bubbles_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel %h (last %b), nothing pending",
                 $time, out_pixel, out_last_pixel);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel !== want.pixel) begin
          errors++;
          $display("%0t: pixel mismatch, expected %h, actual %h",
                   $time, want.pixel, out_pixel);
        end
        if (out_last_pixel !== want.last_pixel) begin
          errors++;
          $display("%0t: last_pixel mismatch, expected %b, actual %b",
                   $time, want.last_pixel, out_last_pixel);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_voxel(input logic [vip_pkg::VOX_W-1:0] v);
    int unsigned gap;
    if (bubbles_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_voxel <= v;
    do @(posedge clk); while (!in_ready);
    project_voxel(v);
    items_sent++;
    stream_dirty = 1'b1;
  endtask

  task automatic in_stop();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_pixels();
    in_stop();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Voxels outside the last slice leave no trace at the output, so the unit
  // gets time to finish any divide before a register changes.
  task automatic cfg_write(input vip_pkg::cfg_idx_t idx,
                           input logic [vip_pkg::CFG_DATA_W-1:0] d);
    if (stream_dirty) begin
      drain_pixels();
      repeat (SETTLE_CYCLES) @(posedge clk);
      stream_dirty = 1'b0;
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_volume(input vip_pkg::mode_t m,
                            input logic [vip_pkg::CFG_DATA_W-1:0] w,
                            input logic [vip_pkg::CFG_DATA_W-1:0] h,
                            input logic [vip_pkg::CFG_DATA_W-1:0] d);
    cfg_write(vip_pkg::CFG_MODE, vip_pkg::CFG_DATA_W'(m));
    cfg_write(vip_pkg::CFG_WIDTH, w);
    cfg_write(vip_pkg::CFG_HEIGHT, h);
    cfg_write(vip_pkg::CFG_DEPTH, d);
  endtask

  // Sends voxels until the volume in progress is complete.
  task automatic stream_volume(input bit saturated = 1'b0);
    do send_voxel(saturated ? '1 : pick_voxel());
    while (col_cnt != 0 || row_cnt != 0 || slice_cnt != 0);
    volumes_done++;
  endtask

  task automatic test_max_projection();
    set_volume(vip_pkg::MODE_MIP, 2, 1, 2);
    send_voxel('0);
    send_voxel('1);
    send_voxel('1);
    send_voxel('0);
    volumes_done++;
  endtask

  task automatic test_min_projection();
    set_volume(vip_pkg::MODE_MINIP, 2, 1, 2);
    send_voxel('1);
    send_voxel(16'h1234);
    send_voxel('0);
    send_voxel('1);
    volumes_done++;
  endtask

  task automatic test_average_projection();
    set_volume(vip_pkg::MODE_AIP, 2, 1, 3);
    send_voxel('1);
    send_voxel(16'h0001);
    send_voxel('1);
    send_voxel(16'h0002);
    send_voxel('1);
    send_voxel(16'h0002);
    volumes_done++;
  endtask

  // Zero sizes count as one, so every voxel is its own last slice. The
  // unknown mode code must leave average mode in force.
  task automatic test_single_slice();
    set_volume(vip_pkg::MODE_AIP, 0, 2, 0);
    cfg_write(vip_pkg::CFG_MODE, vip_pkg::CFG_DATA_W'(INVALID_MODE));
    send_voxel('1);
    send_voxel(16'h0001);
    volumes_done++;
  endtask

  // Depth and width shrink partway into the third slice: the column counter
  // wraps at once and the sum of three slices over two overflows 16 bits.
  task automatic test_midvolume_change();
    set_volume(vip_pkg::MODE_AIP, 3, 1, 4);
    repeat (7) send_voxel('1);
    cfg_write(vip_pkg::CFG_DEPTH, 2);
    cfg_write(vip_pkg::CFG_WIDTH, 1);
    send_voxel('1);
    volumes_done++;
  endtask

  task automatic test_backpressure();
    bubbles_on = 1'b0;
    set_volume(vip_pkg::MODE_MIP, 8, 4, 1);
    repeat (4) send_voxel(pick_voxel());
    hold_req = LONG_HOLD;
    stream_volume();
    set_volume(vip_pkg::MODE_MINIP, 6, 2, 2);
    repeat (18) send_voxel(pick_voxel());
    drain_pixels();
    stream_volume();
    bubbles_on = 1'b1;
  endtask

  // An oversized depth is held at the deepest stack; a full-scale sum over
  // all of it still fits the accumulator.
  task automatic test_largest_depth();
    set_volume(vip_pkg::MODE_AIP, 1, 1, 10'h3FF);
    stream_volume(1'b1);
  endtask

  task automatic test_random_volumes();
    int unsigned    start, w, h, d;
    vip_pkg::mode_t m;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      bubbles_on = (items_sent - start < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
      m = vip_pkg::mode_t'($urandom_range(0, 2));
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
      h = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
      d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 4);
      if (clamp_dim(w, vip_pkg::MAX_WIDTH) * clamp_dim(h, vip_pkg::MAX_HEIGHT) *
          clamp_dim(d, vip_pkg::MAX_DEPTH) > 240)
        d = 1;
      set_volume(m, vip_pkg::CFG_DATA_W'(w), vip_pkg::CFG_DATA_W'(h),
                 vip_pkg::CFG_DATA_W'(d));
      if ($urandom_range(0, 5) == 0)
        cfg_write(vip_pkg::CFG_MODE, vip_pkg::CFG_DATA_W'(INVALID_MODE));
      stream_volume();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_voxel  = '0;
    cfg_valid = 1'b0;
    cfg_index = vip_pkg::CFG_MODE;
    cfg_data  = '0;
    col_cnt = 0;
    row_cnt = 0;
    slice_cnt = 0;
    proj_mode = vip_pkg::MODE_MIP;
    img_width = 256;
    img_height = 256;
    stack_depth = 128;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_max_projection();
    test_min_projection();
    test_average_projection();
    test_single_slice();
    test_midvolume_change();
    test_backpressure();
    test_largest_depth();
    test_random_volumes();

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d volumes: %0d voxels in, %0d projected pixels checked.",
             volumes_done, items_sent, pixels_checked);
    $display("Modes max/average/min, zero and oversized sizes, deepest stack, mid-volume "
             , "changes, stalls.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
